[hw/rtl/rectangle_raster_painter_core_defines.svh]
// assertion helpers for the rectangle raster painter
// each expects clk_i and rst_ni in the scope where it is used
`ifndef RECTANGLE_RASTER_PAINTER_CORE_DEFINES_SVH
`define RECTANGLE_RASTER_PAINTER_CORE_DEFINES_SVH

// same-cycle implication
`define RRP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rrp_pkg.sv]
`timescale 1ns / 1ps

package rrp_pkg;

  // frame geometry
  localparam int MAX_SIDE    = 512;
  localparam int FRAC_BITS   = 8;
  localparam int SIDE_BITS   = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 2 * SIDE_BITS;
  localparam int FRAME_DEPTH = MAX_SIDE * MAX_SIDE;

  // field widths
  localparam int ZONE_W  = 10;
  localparam int CHAR_W  = 8;
  localparam int CODE_W  = 8;
  localparam int COORD_W = 19;
  localparam int SIZE_W  = 18;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int GEO_W   = COORD_W + 2;
  localparam int STEP_W  = 4;

  localparam logic [SIDE_BITS-1:0] SIDE_LAST = SIDE_BITS'(MAX_SIDE - 1);
  localparam logic [ZONE_W-1:0] ZONE_MAX = ZONE_W'(MAX_SIDE);
  localparam logic signed [GEO_W-1:0] GEO_ONE = GEO_W'(1 << FRAC_BITS);

  localparam logic [CODE_W-1:0] CODE_OUTLINE = 8'h72;
  localparam logic [CODE_W-1:0] CODE_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] BACKGROUND_RESET = 8'h20;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECTED = 2'd1,
    ST_SKIPPED  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ZONE_WIDTH  = 2'd0,
    REG_ZONE_HEIGHT = 2'd1,
    REG_BACKGROUND  = 2'd2
  } reg_idx_e;

  // datapath operations driven by the microcode
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_TAKE,
    ACT_EMIT,
    ACT_CLR_START,
    ACT_CLR_WRITE,
    ACT_SCAN_START,
    ACT_PAINT,
    ACT_SKIP,
    ACT_REJECT,
    ACT_LOAD_PIXEL,
    ACT_OUTSIDE
  } act_e;

  // branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_FIRE,
    C_IS_CLEAR,
    C_IS_DRAW,
    C_IS_READ,
    C_OUT_FREE,
    C_SCAN_LAST,
    C_FLAG_SET,
    C_BAD,
    C_OUTSIDE
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    logic  loop;    // repeat this step while the condition is false
    step_t target;  // taken when the condition is true
  } ctrl_word_t;

  // status flags the datapath hands to the sequencer
  typedef struct packed {
    logic in_fire;
    logic is_clear;
    logic is_draw;
    logic is_read;
    logic out_free;
    logic scan_last;
    logic flag_set;
    logic bad;
    logic outside;
  } flags_t;

  // program addresses
  localparam step_t S_WAIT      = 4'd0;
  localparam step_t S_DISP_CLR  = 4'd1;
  localparam step_t S_DISP_DRW  = 4'd2;
  localparam step_t S_DISP_RD   = 4'd3;
  localparam step_t S_EMIT      = 4'd4;
  localparam step_t S_CLR_START = 4'd5;
  localparam step_t S_CLR_LOOP  = 4'd6;
  localparam step_t S_DRW_FLAG  = 4'd7;
  localparam step_t S_DRW_BAD   = 4'd8;
  localparam step_t S_DRW_START = 4'd9;
  localparam step_t S_DRW_LOOP  = 4'd10;
  localparam step_t S_SKIP      = 4'd11;
  localparam step_t S_REJECT    = 4'd12;
  localparam step_t S_RD_CHK    = 4'd13;
  localparam step_t S_RD_LOAD   = 4'd14;
  localparam step_t S_RD_OUT    = 4'd15;

  function automatic ctrl_word_t ucode_rom(step_t pc);
    ctrl_word_t w;
    unique case (pc)
      S_WAIT:      w = '{ACT_TAKE,       C_IN_FIRE,   1'b1, S_DISP_CLR};
      S_DISP_CLR:  w = '{ACT_NOP,        C_IS_CLEAR,  1'b0, S_CLR_START};
      S_DISP_DRW:  w = '{ACT_NOP,        C_IS_DRAW,   1'b0, S_DRW_FLAG};
      S_DISP_RD:   w = '{ACT_NOP,        C_IS_READ,   1'b0, S_RD_CHK};
      S_EMIT:      w = '{ACT_EMIT,       C_OUT_FREE,  1'b1, S_WAIT};
      S_CLR_START: w = '{ACT_CLR_START,  C_NEVER,     1'b0, S_CLR_LOOP};
      S_CLR_LOOP:  w = '{ACT_CLR_WRITE,  C_SCAN_LAST, 1'b1, S_EMIT};
      S_DRW_FLAG:  w = '{ACT_NOP,        C_FLAG_SET,  1'b0, S_SKIP};
      S_DRW_BAD:   w = '{ACT_NOP,        C_BAD,       1'b0, S_REJECT};
      S_DRW_START: w = '{ACT_SCAN_START, C_NEVER,     1'b0, S_DRW_LOOP};
      S_DRW_LOOP:  w = '{ACT_PAINT,      C_SCAN_LAST, 1'b1, S_EMIT};
      S_SKIP:      w = '{ACT_SKIP,       C_ALWAYS,    1'b0, S_EMIT};
      S_REJECT:    w = '{ACT_REJECT,     C_ALWAYS,    1'b0, S_EMIT};
      S_RD_CHK:    w = '{ACT_NOP,        C_OUTSIDE,   1'b0, S_RD_OUT};
      S_RD_LOAD:   w = '{ACT_LOAD_PIXEL, C_ALWAYS,    1'b0, S_EMIT};
      S_RD_OUT:    w = '{ACT_OUTSIDE,    C_ALWAYS,    1'b0, S_EMIT};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/rrp_channels.sv]
`timescale 1ns / 1ps

// input item channel
interface rrp_in_if;
  import rrp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [CODE_W-1:0]          shape_code;
  logic signed [COORD_W-1:0]  rect_x;
  logic signed [COORD_W-1:0]  rect_y;
  logic [SIZE_W-1:0]          rect_w;
  logic [SIZE_W-1:0]          rect_h;
  logic [CHAR_W-1:0]          color;
  logic [SIDE_BITS-1:0]       pixel_col;
  logic [SIDE_BITS-1:0]       pixel_row;

  modport source (output valid, kind, shape_code, rect_x, rect_y, rect_w, rect_h, color,
                  pixel_col, pixel_row, input ready);
  modport sink (input valid, kind, shape_code, rect_x, rect_y, rect_w, rect_h, color,
                pixel_col, pixel_row, output ready);
endinterface

// result item channel
interface rrp_out_if;
  import rrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel;
  logic [1:0]        status;

  modport source (output valid, pixel, status, input ready);
  modport sink (input valid, pixel, status, output ready);
endinterface

// register write channel
interface rrp_cfg_if;
  import rrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [ZONE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/rrp_sequencer.sv]
`timescale 1ns / 1ps

module rrp_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrp_pkg::flags_t flags_i,
  output rrp_pkg::act_e   act_o
);
  import rrp_pkg::*;

  step_t      pc_q, pc_d;
  ctrl_word_t word;
  logic       branch;

  assign word  = ucode_rom(pc_q);
  assign act_o = word.act;

  always_comb begin
    unique case (word.cond)
      C_NEVER:     branch = 1'b0;
      C_ALWAYS:    branch = 1'b1;
      C_IN_FIRE:   branch = flags_i.in_fire;
      C_IS_CLEAR:  branch = flags_i.is_clear;
      C_IS_DRAW:   branch = flags_i.is_draw;
      C_IS_READ:   branch = flags_i.is_read;
      C_OUT_FREE:  branch = flags_i.out_free;
      C_SCAN_LAST: branch = flags_i.scan_last;
      C_FLAG_SET:  branch = flags_i.flag_set;
      C_BAD:       branch = flags_i.bad;
      C_OUTSIDE:   branch = flags_i.outside;
      default:     branch = 1'b0;
    endcase
  end

  always_comb begin
    if (branch) begin
      pc_d = word.target;
    end else if (word.loop) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[hw/rtl/rectangle_raster_painter_core.sv]
`timescale 1ns / 1ps
// channel   | dir | handshake      | payload
// ----------+-----+----------------+-----------------------------------------------
// in_ch     | in  | valid / ready  | kind, shape_code, rect_x/y/w/h, color,
//           |     |                | pixel_col, pixel_row
// out_ch    | out | valid / ready  | pixel, status
// cfg_ch    | in  | valid / ready  | index (0 zone_width, 1 zone_height, 2 background),
//           |     |                | data
//
// one item at a time; the scan loop steps over one frame pixel per cycle and writes
// through the single write port of the frame store; clear and draw sweep the zw*zh zone
// a finished result sits in the output register while the next item is taken
// reset clears control and configuration registers only; frame contents are unknown until a clear
// cfg_ch is always ready; a stalled out_ch holds the sequencer in its emit step
`include "rectangle_raster_painter_core_defines.svh"

module rectangle_raster_painter_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  rrp_in_if.sink   in_ch,
  rrp_out_if.source out_ch,
  rrp_cfg_if.sink  cfg_ch
);
  import rrp_pkg::*;

  // configuration registers
  logic [ZONE_W-1:0]    zone_width_q, zone_height_q;
  logic [CHAR_W-1:0]    background_q;
  logic [SIDE_BITS-1:0] last_col, last_row;

  // latched item
  kind_e                     kind_q;
  logic                      filled_q, bad_q;
  logic signed [COORD_W-1:0] sx_q, sy_q;
  logic signed [EDGE_W-1:0]  ex_q, ey_q;
  logic [CHAR_W-1:0]         color_q;

  // scan / address counters, shared by clear, draw and read
  logic [SIDE_BITS-1:0] col_q, row_q;
  logic                 col_wrap, scan_last, outside;

  // pending result and output register
  logic [CHAR_W-1:0] res_pixel_q, out_pixel_q;
  status_e           res_status_q, out_status_q;
  logic              out_valid_q, out_free, out_load;

  logic   rejected_q;
  act_e   act;
  flags_t flags;
  logic   in_fire;

  // frame store
  logic [CHAR_W-1:0] frame_mem_q [FRAME_DEPTH];
  logic [CHAR_W-1:0] rdata_q, mem_wdata;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;

  // geometry
  logic signed [GEO_W-1:0] px, py, dx_lo, dx_hi, dy_lo, dy_hi;
  logic                    in_x, in_y, edge_x, edge_y, covered;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_width_q  <= ZONE_W'(1);
      zone_height_q <= ZONE_W'(1);
      background_q  <= BACKGROUND_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (reg_idx_e'(cfg_ch.index))
        REG_ZONE_WIDTH:  zone_width_q  <= cfg_ch.data;
        REG_ZONE_HEIGHT: zone_height_q <= cfg_ch.data;
        REG_BACKGROUND:  background_q  <= cfg_ch.data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // zone clamp: zero acts as one, oversize acts as the full side
  always_comb begin
    if (zone_width_q == '0) begin
      last_col = '0;
    end else if (zone_width_q > ZONE_MAX) begin
      last_col = SIDE_LAST;
    end else begin
      last_col = SIDE_BITS'(zone_width_q - ZONE_W'(1));
    end
    if (zone_height_q == '0) begin
      last_row = '0;
    end else if (zone_height_q > ZONE_MAX) begin
      last_row = SIDE_LAST;
    end else begin
      last_row = SIDE_BITS'(zone_height_q - ZONE_W'(1));
    end
  end

  // ---------------------------------------------------------------- sequencer
  rrp_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  assign in_ch.ready = (act == ACT_TAKE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign col_wrap  = (col_q == last_col);
  assign scan_last = col_wrap && (row_q == last_row);
  assign outside   = (col_q > last_col) || (row_q > last_row);

  assign out_free = !out_valid_q || out_ch.ready;
  assign out_load = (act == ACT_EMIT) && out_free;

  always_comb begin
    flags.in_fire   = in_fire;
    flags.is_clear  = (kind_q == KIND_CLEAR);
    flags.is_draw   = (kind_q == KIND_DRAW);
    flags.is_read   = (kind_q == KIND_READ);
    flags.out_free  = out_free;
    flags.scan_last = scan_last;
    flags.flag_set  = rejected_q;
    flags.bad       = bad_q;
    flags.outside   = outside;
  end

  // ---------------------------------------------------------------- item latch
  // far edges are formed once per item, the scan only subtracts and compares
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= kind_e'(in_ch.kind);
      filled_q <= (in_ch.shape_code == CODE_FILLED);
      bad_q    <= ((in_ch.shape_code != CODE_OUTLINE) && (in_ch.shape_code != CODE_FILLED))
                  || (in_ch.rect_w == '0) || (in_ch.rect_h == '0);
      sx_q     <= in_ch.rect_x;
      sy_q     <= in_ch.rect_y;
      ex_q     <= EDGE_W'(in_ch.rect_x) + signed'(EDGE_W'(in_ch.rect_w));
      ey_q     <= EDGE_W'(in_ch.rect_y) + signed'(EDGE_W'(in_ch.rect_h));
      color_q  <= in_ch.color;
    end
  end

  // counters: loaded with the read address on take, swept by the scan loops
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= in_ch.pixel_col;
      row_q <= in_ch.pixel_row;
    end else if (act == ACT_CLR_START || act == ACT_SCAN_START) begin
      col_q <= '0;
      row_q <= '0;
    end else if (act == ACT_CLR_WRITE || act == ACT_PAINT) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_q + SIDE_BITS'(1);
      end else begin
        col_q <= col_q + SIDE_BITS'(1);
      end
    end
  end

  // ---------------------------------------------------------------- coverage test
  // pixel point scaled to fixed point, closed rectangle, border within one pixel
  assign px    = signed'(GEO_W'({col_q, {FRAC_BITS{1'b0}}}));
  assign py    = signed'(GEO_W'({row_q, {FRAC_BITS{1'b0}}}));
  assign dx_lo = px - GEO_W'(sx_q);
  assign dx_hi = GEO_W'(ex_q) - px;
  assign dy_lo = py - GEO_W'(sy_q);
  assign dy_hi = GEO_W'(ey_q) - py;

  assign in_x    = !dx_lo[GEO_W-1] && !dx_hi[GEO_W-1];
  assign in_y    = !dy_lo[GEO_W-1] && !dy_hi[GEO_W-1];
  assign edge_x  = (dx_lo < GEO_ONE) || (dx_hi < GEO_ONE);
  assign edge_y  = (dy_lo < GEO_ONE) || (dy_hi < GEO_ONE);
  assign covered = in_x && in_y && (filled_q || edge_x || edge_y);

  // ---------------------------------------------------------------- frame store
  assign mem_addr  = {row_q, col_q};
  assign mem_we    = (act == ACT_CLR_WRITE) || ((act == ACT_PAINT) && covered);
  assign mem_wdata = (act == ACT_CLR_WRITE) ? background_q : color_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= frame_mem_q[mem_addr];
  end

  // ---------------------------------------------------------------- rejection flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rejected_q <= 1'b0;
    end else if (act == ACT_CLR_START) begin
      rejected_q <= 1'b0;
    end else if (act == ACT_REJECT) begin
      rejected_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_pixel_q  <= '0;
      res_status_q <= ST_OK;
    end else begin
      unique case (act)
        ACT_SKIP:       res_status_q <= ST_SKIPPED;
        ACT_REJECT:     res_status_q <= ST_REJECTED;
        ACT_OUTSIDE:    res_status_q <= ST_OUTSIDE;
        ACT_LOAD_PIXEL: res_pixel_q  <= rdata_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pixel_q  <= res_pixel_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.pixel  = out_pixel_q;
  assign out_ch.status = out_status_q;

  // ---------------------------------------------------------------- checks
  `RRP_ASSERT_IMPLIES(a_write_in_zone, mem_we, (col_q <= last_col) && (row_q <= last_row), "frame write outside zone")
  `RRP_ASSERT_IMPLIES(a_outside_no_pixel, out_ch.valid && (out_ch.status == ST_OUTSIDE), out_ch.pixel == '0, "outside read with pixel")
  `RRP_ASSERT_NEXT(a_one_item, in_fire, !in_ch.ready, "item taken while busy")

endmodule
